>>> design/fftrp_pkg.sv
// Shared types, widths and codes for the first-fit two-resource packer.
`default_nettype none
package fftrp_pkg;

   localparam int CPU_W           = 10;
   localparam int MEM_W           = 20;
   localparam int STATUS_W        = 3;
   localparam int INDEX_OUT_W     = 6;
   localparam int OPEN_OUT_W      = 7;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 20;
   localparam int MAX_SERVERS_DEF = 64;

   localparam logic [CPU_W-1:0] CPU_CAP_RESET = 10'd1023;
   localparam logic [MEM_W-1:0] MEM_CAP_RESET = 20'd1048575;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_CAP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEM_CAP = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_EXISTING  = 3'd0,
      ST_NEW       = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_CHECK,
      S_OPEN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic             op;
      logic [CPU_W-1:0] cpu_need;
      logic [MEM_W-1:0] mem_need;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [INDEX_OUT_W-1:0] server_index;
      logic [OPEN_OUT_W-1:0]  servers_open;
   } rsp_type;

   typedef struct packed {
      logic [CPU_W-1:0] cpu_avail;
      logic [MEM_W-1:0] mem_avail;
      logic [CPU_W-1:0] cpu_need;
      logic [MEM_W-1:0] mem_need;
   } fit_in_type;

   typedef struct packed {
      logic             fits;
      logic [CPU_W-1:0] cpu_rem;
      logic [MEM_W-1:0] mem_rem;
   } fit_out_type;

endpackage
`default_nettype wire

>>> design/first_fit_two_resource_packer_unit.sv
// Top level of the first-fit two-resource packer: sequencer, server table and ports.
`default_nettype none
// First-fit packer for requests needing CPU and memory. Each allocate transaction is
// checked against the configured server capacity, then the open servers are scanned
// from index 0 and the request goes to the first one with room for both needs; if
// none has room a new server is opened, and with MAX_SERVERS open the result is
// "table full". A clear transaction closes all servers. One transaction is worked
// at a time and req_stall stays high until its result is in the output register.
// A clear or an oversized request goes from the decode state straight to the finish
// state; an allocate reads and checks the open entries one by one until a hit, and
// goes through the open state when it must open a server or finds the table full.
// The server table has one registered read port and the fit unit is shared, so each
// entry is first read into rd_ff and then checked in the fit unit. The finish state
// waits until the output register is free or being emptied. req_stall drops in the
// same cycle that rsp_valid rises, and a new request is taken then if req_valid is
// high. Capacity registers sit at csr index 0 (CPU) and 1 (memory); csr_ready is
// always high.
module first_fit_two_resource_packer_unit #(
   parameter int MAX_SERVERS = fftrp_pkg::MAX_SERVERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fftrp_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fftrp_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fftrp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fftrp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fftrp_pkg::*;

   localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int SLOT_W = CPU_W + MEM_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SERVERS);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    open_ff, open_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   req_type             item_ff, item_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [CPU_W-1:0]    cpu_cap_ff;
   logic [MEM_W-1:0]    mem_cap_ff;

   logic [SLOT_W-1:0]   slot_ff [MAX_SERVERS];
   logic [SLOT_W-1:0]   rd_ff;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   logic                  use_capacity;
   fit_in_type            fit_in;
   fit_out_type           fit_out;
   logic [CNT_W-1:0]      idx_next_cnt;
   logic [IDX_W+INDEX_OUT_W-1:0] idx_wide;
   logic [CNT_W+OPEN_OUT_W-1:0]  open_wide;

   // Capacity registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_cap_ff <= CPU_CAP_RESET;
         mem_cap_ff <= MEM_CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CPU_CAP: cpu_cap_ff <= csr_wdata[CPU_W-1:0];
            CSR_MEM_CAP: mem_cap_ff <= csr_wdata[MEM_W-1:0];
            default: ;
         endcase
      end
   end

   // Shared fit unit: compares against full capacity or against the entry just read.
   always_comb begin
      fit_in.cpu_need = item_ff.cpu_need;
      fit_in.mem_need = item_ff.mem_need;
      if (use_capacity) begin
         fit_in.cpu_avail = cpu_cap_ff;
         fit_in.mem_avail = mem_cap_ff;
      end else begin
         fit_in.cpu_avail = rd_ff[SLOT_W-1:MEM_W];
         fit_in.mem_avail = rd_ff[MEM_W-1:0];
      end
   end

   fftrp_fit_unit u_fit (
      .fit_in  (fit_in),
      .fit_out (fit_out)
   );

   // Server table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= {fit_out.cpu_rem, fit_out.mem_rem};
      end
      rd_ff <= slot_ff[idx_ff];
   end

   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_wide     = {{INDEX_OUT_W{1'b0}}, res_idx_ff};
   assign open_wide    = {{OPEN_OUT_W{1'b0}}, open_ff};

   always_comb begin
      state_in      = state_ff;
      open_in       = open_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      use_capacity  = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = open_ff[IDX_W-1:0];
      req_stall     = (state_ff != S_IDLE);

      // Drop the output once taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in     = '0;
            res_idx_in = '0;
            if (item_ff.op == OP_CLEAR) begin
               open_in       = '0;
               res_status_in = ST_CLEARED;
               state_in      = S_FINISH;
            end else if (!fit_out.fits) begin
               res_status_in = ST_TOO_LARGE;
               state_in      = S_FINISH;
            end else if (open_ff == '0) begin
               state_in = S_OPEN;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Address is idx_ff; data lands in rd_ff for the check cycle.
            state_in = S_CHECK;
         end
         S_CHECK: begin
            use_capacity = 1'b0;
            if (fit_out.fits) begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               res_status_in = ST_EXISTING;
               res_idx_in    = idx_ff;
               state_in      = S_FINISH;
            end else if (idx_next_cnt == open_ff) begin
               state_in = S_OPEN;
            end else begin
               idx_in   = idx_next_cnt[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_OPEN: begin
            if (open_ff == CNT_MAX) begin
               res_status_in = ST_FULL;
               res_idx_in    = '0;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = open_ff[IDX_W-1:0];
               res_status_in = ST_NEW;
               res_idx_in    = open_ff[IDX_W-1:0];
               open_in       = open_ff + CNT_W'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // Hold until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.server_index = idx_wide[INDEX_OUT_W-1:0];
               rsp_data_in.servers_open = open_wide[OPEN_OUT_W-1:0];
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      item_ff       <= item_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> design/fftrp_fit_unit.sv
// Shared fit check: subtracts both needs from both available amounts and flags a fit.
`default_nettype none
module fftrp_fit_unit (
   input  fftrp_pkg::fit_in_type  fit_in,
   output fftrp_pkg::fit_out_type fit_out
);
   import fftrp_pkg::*;

   logic [CPU_W:0] cpu_diff;
   logic [MEM_W:0] mem_diff;

   assign cpu_diff = {1'b0, fit_in.cpu_avail} - {1'b0, fit_in.cpu_need};
   assign mem_diff = {1'b0, fit_in.mem_avail} - {1'b0, fit_in.mem_need};

   // A borrow out of either difference means the need exceeds what is left.
   assign fit_out.fits    = ~cpu_diff[CPU_W] & ~mem_diff[MEM_W];
   assign fit_out.cpu_rem = cpu_diff[CPU_W-1:0];
   assign fit_out.mem_rem = mem_diff[MEM_W-1:0];

endmodule
`default_nettype wire
